// ----- design/vsb_pkg.sv -----
// vsb_pkg: shared types, codes and saturation helpers for the vertex skinning blend core
// depends on nothing; imported by vsb_ctrl, vsb_datapath and vertex_skinning_blend_core
`default_nettype none

package vsb_pkg;

  // default sizes
  localparam int VSB_BONES     = 64;
  localparam int VSB_MAX_BLEND = 3;

  // request operations
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_VERTEX = 2'd1;
  localparam logic [1:0] OP_BLEND  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_RIGID_MODE   = 2'd0;
  localparam logic [1:0] CFG_RIGID_BONE   = 2'd1;
  localparam logic [1:0] CFG_VERTEX_COUNT = 2'd2;

  // input request payload
  typedef struct packed {
    logic        [1:0]  operation;
    logic        [5:0]  bone_index;
    logic        [1:0]  slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [31:0] tex_u;
    logic        [31:0] tex_v;
    logic        [15:0] weight;
  } in_req_t;

  // result payload
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic        [31:0] out_u;
    logic        [31:0] out_v;
    logic               surface_end;
  } out_rsp_t;

  // controller state
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_XF,
    ST_FIN,
    ST_BACC,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       accept;
    logic       load_wr;
    logic       issue;
    logic [1:0] col;
    logic       clear;
    logic       fin_vertex;
    logic       fin_blend;
    logic       bacc_add;
    logic       emit;
    logic       surface_end;
    logic [5:0] bone;
  } vsb_cmd_t;

  // clamp a wide sum to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sh0_7FFF_FFFF;
    lo = -50'sh0_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // clamp a rounded normal to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sh0_7FFF;
    lo = -34'sh0_8000;
    if (v > hi) begin
      return 16'sh7FFF;
    end else if (v < lo) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/vsb_datapath.sv -----
// vsb_datapath: bone palette banks, multiply pipeline, accumulators and result register
// depends on vsb_pkg; driven by the command struct from vsb_ctrl
`default_nettype none

module vsb_datapath import vsb_pkg::*; #(
  parameter int BONES = VSB_BONES
) (
  input  wire logic     clk,
  input  wire in_req_t  in_req,
  input  wire vsb_cmd_t cmd,
  output out_rsp_t      out_rsp
);

  localparam int BW    = (BONES > 1) ? $clog2(BONES) : 1;
  localparam int AW    = BW + 2;
  localparam int DEPTH = BONES * 4;

  // latched request
  logic signed [31:0] it_p_r [3];
  logic signed [15:0] it_n_r [3];
  logic        [31:0] it_u_r;
  logic        [31:0] it_v_r;
  logic        [15:0] it_w_r;
  logic        [1:0]  it_slot_r;
  logic        [BW-1:0] bone_r;
  logic               oob_r;
  logic        [8:0]  bone_ext;

  assign bone_ext = {3'b000, cmd.bone};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      it_p_r[0] <= in_req.coord_x;
      it_p_r[1] <= in_req.coord_y;
      it_p_r[2] <= in_req.coord_z;
      it_n_r[0] <= in_req.normal_x;
      it_n_r[1] <= in_req.normal_y;
      it_n_r[2] <= in_req.normal_z;
      it_u_r    <= in_req.tex_u;
      it_v_r    <= in_req.tex_v;
      it_w_r    <= in_req.weight;
      it_slot_r <= in_req.slot;
      bone_r    <= bone_ext[BW-1:0];
      oob_r     <= (bone_ext >= 9'(BONES));
    end
  end

  // palette banks, one per matrix row, addressed by bone and column
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_r [3];

  assign wr_addr = {bone_r, it_slot_r};
  assign rd_addr = {bone_r, cmd.col};

  for (genvar r = 0; r < 3; r++) begin : g_bank
    logic [31:0] mem [DEPTH];
    always_ff @(posedge clk) begin
      if (cmd.load_wr && !oob_r) begin
        mem[wr_addr] <= it_p_r[r];
      end
      if (cmd.issue) begin
        rd_r[r] <= mem[rd_addr];
      end
    end
  end

  // read pipeline tags
  logic       v_d1_r;
  logic       v_d2_r;
  logic [1:0] col_d1_r;
  logic [1:0] col_d2_r;

  always_ff @(posedge clk) begin
    v_d1_r   <= cmd.issue;
    v_d2_r   <= v_d1_r;
    col_d1_r <= cmd.col;
    col_d2_r <= col_d1_r;
  end

  // operand select for the current column
  logic signed [31:0] m_sel [3];
  logic signed [31:0] p_sel;
  logic signed [15:0] n_sel;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      m_sel[r] = oob_r ? 32'sd0 : rd_r[r];
    end
    case (col_d1_r)
      2'd0: begin
        p_sel = it_p_r[0];
        n_sel = it_n_r[0];
      end
      2'd1: begin
        p_sel = it_p_r[1];
        n_sel = it_n_r[1];
      end
      2'd2: begin
        p_sel = it_p_r[2];
        n_sel = it_n_r[2];
      end
      default: begin
        p_sel = 32'sd0;
        n_sel = 16'sd0;
      end
    endcase
  end

  // product stage
  logic signed [63:0] prod_p_r [3];
  logic signed [47:0] prod_n_r [3];
  logic signed [31:0] m_d2_r   [3];

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      prod_p_r[r] <= p_sel * m_sel[r];
      prod_n_r[r] <= n_sel * m_sel[r];
      m_d2_r[r]   <= m_sel[r];
    end
  end

  // accumulate stage: rounded position products plus translation, exact normal sum
  logic signed [49:0] pacc_r [3];
  logic signed [49:0] nacc_r [3];
  logic signed [63:0] rp_t   [3];
  logic signed [47:0] rp     [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rp_t[r] = prod_p_r[r] + 64'sd32768;
      rp[r]   = rp_t[r][63:16];
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      if (cmd.clear) begin
        pacc_r[r] <= 50'sd0;
        nacc_r[r] <= 50'sd0;
      end else if (v_d2_r) begin
        if (col_d2_r == 2'd3) begin
          pacc_r[r] <= pacc_r[r] + {{18{m_d2_r[r][31]}}, m_d2_r[r]};
        end else begin
          pacc_r[r] <= pacc_r[r] + {{2{rp[r][47]}}, rp[r]};
          nacc_r[r] <= nacc_r[r] + {{2{prod_n_r[r][47]}}, prod_n_r[r]};
        end
      end
    end
  end

  // held vertex state and blend terms
  logic signed [31:0] p0_r   [3];
  logic signed [15:0] hn_r   [3];
  logic        [31:0] hu_r;
  logic        [31:0] hv_r;
  logic signed [47:0] bacc_r [3];
  logic signed [49:0] prod_b_r [3];
  logic signed [49:0] nr_t   [3];
  logic signed [33:0] nr     [3];
  logic signed [31:0] q      [3];
  logic signed [32:0] diff   [3];
  logic signed [16:0] w_s;
  logic signed [49:0] rb_t   [3];
  logic signed [33:0] rb     [3];
  logic signed [49:0] fin_sum [3];
  logic signed [31:0] pos    [3];

  assign w_s = {1'b0, it_w_r};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nr_t[r]    = nacc_r[r] + 50'sd32768;
      nr[r]      = nr_t[r][49:16];
      q[r]       = sat32(pacc_r[r]);
      diff[r]    = {q[r][31], q[r]} - {p0_r[r][31], p0_r[r]};
      rb_t[r]    = prod_b_r[r] + 50'sd32768;
      rb[r]      = rb_t[r][49:16];
      fin_sum[r] = {{18{p0_r[r][31]}}, p0_r[r]} + {{2{bacc_r[r][47]}}, bacc_r[r]};
      pos[r]     = sat32(fin_sum[r]);
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      if (cmd.fin_vertex) begin
        p0_r[r]   <= q[r];
        hn_r[r]   <= sat16(nr[r]);
        bacc_r[r] <= 48'sd0;
      end else if (cmd.bacc_add) begin
        bacc_r[r] <= bacc_r[r] + {{14{rb[r][33]}}, rb[r]};
      end
      if (cmd.fin_blend) begin
        prod_b_r[r] <= diff[r] * w_s;
      end
    end
    if (cmd.fin_vertex) begin
      hu_r <= it_u_r;
      hv_r <= it_v_r;
    end
  end

  // result register
  out_rsp_t out_rsp_r;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rsp_r.pos_x       <= pos[0];
      out_rsp_r.pos_y       <= pos[1];
      out_rsp_r.pos_z       <= pos[2];
      out_rsp_r.norm_x      <= hn_r[0];
      out_rsp_r.norm_y      <= hn_r[1];
      out_rsp_r.norm_z      <= hn_r[2];
      out_rsp_r.out_u       <= hu_r;
      out_rsp_r.out_v       <= hv_r;
      out_rsp_r.surface_end <= cmd.surface_end;
    end
  end

  assign out_rsp = out_rsp_r;

endmodule

`default_nettype wire

// ----- design/vsb_ctrl.sv -----
// vsb_ctrl: sequencing state machine, configuration registers, blend and vertex counters
// depends on vsb_pkg; drives vsb_datapath through the command struct
`default_nettype none

module vsb_ctrl import vsb_pkg::*; #(
  parameter int MAX_BLEND = VSB_MAX_BLEND
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_req_t     in_req,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output vsb_cmd_t         cmd
);

  localparam int EW = $clog2(MAX_BLEND + 1);
  localparam logic [2:0] XF_LAST  = 3'd5;
  localparam logic [2:0] XF_ISSUE = 3'd4;
  localparam logic [2:0] MAXB3    = 3'(MAX_BLEND);

  state_t         state_r, state_nxt;
  logic [2:0]     cnt_r, cnt_nxt;
  logic [1:0]     op_r, op_nxt;
  logic [EW-1:0]  ecount_r, ecount_nxt;
  logic [EW-1:0]  entries_r, entries_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [15:0]    vdone_r, vdone_nxt;
  logic           rigid_mode_r, rigid_mode_nxt;
  logic [5:0]     rigid_bone_r, rigid_bone_nxt;
  logic [15:0]    vcount_r, vcount_nxt;

  logic           accept;
  logic           out_free;
  logic           cfg_wr;
  logic [2:0]     slot3;
  logic [2:0]     clamp3;
  logic [15:0]    vnext;
  logic           last;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_wr   = cfg_valid && cfg_ready;
  assign slot3    = {1'b0, in_req.slot};
  assign clamp3   = (slot3 > MAXB3) ? MAXB3 : slot3;
  assign vnext    = vdone_r + 16'd1;
  assign last     = (vcount_r != 16'd0) && (vnext == vcount_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.operation)
            OP_LOAD:   state_nxt = ST_LOAD;
            OP_VERTEX: state_nxt = ST_XF;
            OP_BLEND:  state_nxt = (entries_r != '0) ? ST_XF : ST_IDLE;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: state_nxt = ST_IDLE;
      ST_XF: begin
        if (cnt_r == XF_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (op_r == OP_VERTEX) begin
          state_nxt = (ecount_r == '0) ? ST_EMIT : ST_IDLE;
        end else begin
          state_nxt = ST_BACC;
        end
      end
      ST_BACC: state_nxt = (entries_r == EW'(1)) ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    in_stall        = (state_r != ST_IDLE);
    cfg_ready       = 1'b1;
    out_valid       = out_valid_r;
    cmd             = '0;
    cmd.accept      = accept;
    cmd.bone        = (rigid_mode_r && (in_req.operation == OP_VERTEX)) ? rigid_bone_r
                                                                        : in_req.bone_index;
    cmd.load_wr     = (state_r == ST_LOAD);
    cmd.issue       = (state_r == ST_XF) && (cnt_r < XF_ISSUE);
    cmd.col         = cnt_r[1:0];
    cmd.clear       = (state_r == ST_XF) && (cnt_r == 3'd0);
    cmd.fin_vertex  = (state_r == ST_FIN) && (op_r == OP_VERTEX);
    cmd.fin_blend   = (state_r == ST_FIN) && (op_r != OP_VERTEX);
    cmd.bacc_add    = (state_r == ST_BACC);
    cmd.emit        = (state_r == ST_EMIT) && out_free;
    cmd.surface_end = last;
  end

  // counters, configuration and result valid
  always_comb begin
    cnt_nxt        = (state_r == ST_XF) ? cnt_r + 3'd1 : 3'd0;
    op_nxt         = op_r;
    ecount_nxt     = ecount_r;
    entries_nxt    = entries_r;
    vdone_nxt      = vdone_r;
    rigid_mode_nxt = rigid_mode_r;
    rigid_bone_nxt = rigid_bone_r;
    vcount_nxt     = vcount_r;
    out_valid_nxt  = cmd.emit ? 1'b1 : (out_valid_r && out_stall);

    if (accept) begin
      op_nxt     = in_req.operation;
      ecount_nxt = rigid_mode_r ? '0 : clamp3[EW-1:0];
    end
    if (cmd.fin_vertex) begin
      entries_nxt = ecount_r;
    end else if (cmd.bacc_add) begin
      entries_nxt = entries_r - EW'(1);
    end
    if (cmd.emit) begin
      vdone_nxt = last ? 16'd0 : vnext;
    end
    if (cfg_wr) begin
      case (cfg_index)
        CFG_RIGID_MODE: rigid_mode_nxt = cfg_data[0];
        CFG_RIGID_BONE: rigid_bone_nxt = cfg_data[5:0];
        CFG_VERTEX_COUNT: begin
          vcount_nxt = cfg_data;
          vdone_nxt  = 16'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= 3'd0;
      op_r         <= OP_LOAD;
      ecount_r     <= '0;
      entries_r    <= '0;
      out_valid_r  <= 1'b0;
      vdone_r      <= 16'd0;
      rigid_mode_r <= 1'b0;
      rigid_bone_r <= 6'd0;
      vcount_r     <= 16'd0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      op_r         <= op_nxt;
      ecount_r     <= ecount_nxt;
      entries_r    <= entries_nxt;
      out_valid_r  <= out_valid_nxt;
      vdone_r      <= vdone_nxt;
      rigid_mode_r <= rigid_mode_nxt;
      rigid_bone_r <= rigid_bone_nxt;
      vcount_r     <= vcount_nxt;
    end
  end

`ifndef SYNTHESIS
  // a new result never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result loaded while previous one still held");

  // pending blend entries stay within the configured limit
  a_entries: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(entries_r) <= MAX_BLEND) && (32'(ecount_r) <= MAX_BLEND))
    else $error("blend entry count out of range");

  // transform sweep always finishes into the finish step
  a_xf_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_XF && cnt_r == XF_LAST) |=> (state_r == ST_FIN))
    else $error("transform sweep did not finish");

  // surface end is never flagged without a vertex count
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.surface_end) |-> (vcount_r != 16'd0))
    else $error("surface end with zero vertex count");
`endif

endmodule

`default_nettype wire

// ----- design/vertex_skinning_blend_core.sv -----
// vertex_skinning_blend_core: top level of the linear blend skinning block
// depends on vsb_pkg, vsb_ctrl and vsb_datapath
//
// Usage:
//   in_valid/in_stall/in_req carries requests: load one matrix column into the
//   bone palette, start a vertex, or add a blend entry to the pending vertex.
//   out_valid/out_stall/out_rsp carries one result per completed vertex.
//   cfg_valid/cfg_ready/cfg_index/cfg_data writes rigid_mode (0), rigid_bone (1)
//   and vertex_count (2); cfg_ready is always high.
//   A load request occupies the block for its load state only. A vertex
//   request and each blend entry run the transform sweep and finish states:
//   the four matrix columns are read one per cycle from the row-banked palette
//   and pass through a two-stage multiply and accumulate pipeline, and a blend
//   entry then adds its weighted term in the blend-add state. A result is
//   issued from the emit state, entered after the finish state of a completing
//   vertex request or after the blend-add state of the completing blend entry.
//   Reset clears the controller, counters and configuration; the palette is
//   not cleared and must be loaded before use.
//   While out_stall holds a result, the block takes requests until the next
//   result is due; it then stalls requests until the held one is taken.
`default_nettype none

module vertex_skinning_blend_core import vsb_pkg::*; #(
  parameter int BONES     = VSB_BONES,
  parameter int MAX_BLEND = VSB_MAX_BLEND
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_req_t     in_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_rsp_t         out_rsp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  vsb_cmd_t cmd;

  // sequencing and configuration
  vsb_ctrl #(
    .MAX_BLEND (MAX_BLEND)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // palette and arithmetic
  vsb_datapath #(
    .BONES (BONES)
  ) u_datapath (
    .clk     (clk),
    .in_req  (in_req),
    .cmd     (cmd),
    .out_rsp (out_rsp)
  );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for vertex_skinning_blend_core
// depends on vsb_pkg and the core; a scoreboard class predicts each skinned vertex
`timescale 1ns / 100ps
`default_nettype none

import vsb_pkg::*;

class skin_scoreboard;
  logic signed [31:0] palette [VSB_BONES*12];
  logic signed [31:0] prim [3];
  longint             acc [3];
  logic signed [15:0] nrm [3];
  logic [31:0]        tex [2];
  int unsigned        pending;
  int unsigned        done_cnt;
  bit                 rigid_mode;
  logic [5:0]         rigid_bone;
  logic [15:0]        vcount;
  out_rsp_t           skinned_q [$];
  int                 errors;

  function new();
    foreach (palette[i]) palette[i] = '0;
    foreach (prim[i]) begin
      prim[i] = '0; acc[i] = 0; nrm[i] = '0;
    end
    tex[0] = '0; tex[1] = '0;
    pending = 0; done_cnt = 0; rigid_mode = 0; rigid_bone = '0; vcount = '0;
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      CFG_RIGID_MODE:   rigid_mode = val[0];
      CFG_RIGID_BONE:   rigid_bone = val[5:0];
      CFG_VERTEX_COUNT: begin
        vcount = val;
        done_cnt = 0;
      end
      default: ;
    endcase
  endfunction

  // round to nearest by adding half and flooring the shift
  function longint rnd16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function void xform_pt(int b, longint p [3], output logic signed [31:0] r [3]);
    longint s;
    for (int row = 0; row < 3; row++) begin
      s = palette[b*12 + 9 + row];
      for (int c = 0; c < 3; c++) s += rnd16(p[c] * palette[b*12 + c*3 + row]);
      r[row] = 32'(clamp(s, -64'sd2147483648, 64'sd2147483647));
    end
  endfunction

  function void push_result();
    out_rsp_t r;
    logic [15:0] nxt;
    bit last;
    nxt = 16'(done_cnt + 1);
    last = (vcount != 0) && (nxt == vcount);
    r.pos_x = 32'(clamp(prim[0] + acc[0], -64'sd2147483648, 64'sd2147483647));
    r.pos_y = 32'(clamp(prim[1] + acc[1], -64'sd2147483648, 64'sd2147483647));
    r.pos_z = 32'(clamp(prim[2] + acc[2], -64'sd2147483648, 64'sd2147483647));
    r.norm_x = nrm[0]; r.norm_y = nrm[1]; r.norm_z = nrm[2];
    r.out_u = tex[0]; r.out_v = tex[1];
    r.surface_end = last;
    done_cnt = last ? 0 : nxt;
    skinned_q.push_back(r);
  endfunction

  // note an accepted request and predict what it produces
  function void note_request(in_req_t q);
    longint p [3];
    longint n [3];
    longint s;
    logic signed [31:0] t [3];
    int b;
    int cnt;
    p[0] = q.coord_x; p[1] = q.coord_y; p[2] = q.coord_z;
    b = q.bone_index;
    if (q.operation == OP_LOAD) begin
      for (int i = 0; i < 3; i++) palette[b*12 + q.slot*3 + i] = 32'(p[i]);
    end else if (q.operation == OP_VERTEX) begin
      n[0] = q.normal_x; n[1] = q.normal_y; n[2] = q.normal_z;
      cnt = q.slot;
      if (rigid_mode) begin
        b = rigid_bone;
        cnt = 0;
      end
      if (cnt > VSB_MAX_BLEND) cnt = VSB_MAX_BLEND;
      xform_pt(b, p, prim);
      for (int row = 0; row < 3; row++) begin
        s = 0;
        for (int c = 0; c < 3; c++) s += n[c] * palette[b*12 + c*3 + row];
        nrm[row] = 16'(clamp(rnd16(s), -32768, 32767));
        acc[row] = 0;
      end
      tex[0] = q.tex_u; tex[1] = q.tex_v;
      pending = cnt;
      if (cnt == 0) push_result();
    end else if (q.operation == OP_BLEND && pending > 0) begin
      xform_pt(b, p, t);
      for (int i = 0; i < 3; i++)
        acc[i] += rnd16((longint'(t[i]) - longint'(prim[i])) * longint'({1'b0, q.weight}));
      pending--;
      if (pending == 0) push_result();
    end
  endfunction

  // compare a result with the oldest prediction
  function void check_result(out_rsp_t got);
    out_rsp_t exp_r;
    if (skinned_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = skinned_q.pop_front();
    if (got.pos_x !== exp_r.pos_x || got.pos_y !== exp_r.pos_y ||
        got.pos_z !== exp_r.pos_z || got.norm_x !== exp_r.norm_x ||
        got.norm_y !== exp_r.norm_y || got.norm_z !== exp_r.norm_z ||
        got.out_u !== exp_r.out_u || got.out_v !== exp_r.out_v ||
        got.surface_end !== exp_r.surface_end) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch exp pos %h %h %h nrm %h %h %h uv %h %h end %b",
          exp_r.pos_x, exp_r.pos_y, exp_r.pos_z, exp_r.norm_x, exp_r.norm_y,
          exp_r.norm_z, exp_r.out_u, exp_r.out_v, exp_r.surface_end);
        $display("         got pos %h %h %h nrm %h %h %h uv %h %h end %b",
          got.pos_x, got.pos_y, got.pos_z, got.norm_x, got.norm_y,
          got.norm_z, got.out_u, got.out_v, got.surface_end);
      end
    end
  endfunction
endclass

module tb_top;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_req_t     in_req;
  logic        out_valid;
  logic        out_stall;
  out_rsp_t    out_rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  skin_scoreboard sb;
  bit          hold_out;
  bit          stim_done;

  vertex_skinning_blend_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // drive one request and record it at acceptance; valid stays up for the next one
  task automatic send_req(in_req_t q);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(q);
  endtask

  // drop request valid for a cycle
  task automatic in_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // let outstanding results drain, then the block's own latency
  task automatic drain();
    in_idle();
    while (sb.skinned_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic in_req_t rand_req(logic [1:0] op);
    in_req_t q;
    q.operation = op;
    q.bone_index = 6'($urandom_range(0, 63));
    q.slot = 2'($urandom_range(0, 3));
    q.coord_x = $urandom; q.coord_y = $urandom; q.coord_z = $urandom;
    // keep most coordinates moderate so results do not all saturate
    if ($urandom_range(0, 3) != 0) begin
      q.coord_x = $signed(q.coord_x) >>> $urandom_range(4, 14);
      q.coord_y = $signed(q.coord_y) >>> $urandom_range(4, 14);
      q.coord_z = $signed(q.coord_z) >>> $urandom_range(4, 14);
    end
    q.normal_x = 16'($urandom); q.normal_y = 16'($urandom); q.normal_z = 16'($urandom);
    q.tex_u = $urandom; q.tex_v = $urandom;
    q.weight = 16'($urandom);
    return q;
  endfunction

  task automatic load_all_bones();
    in_req_t q;
    for (int b = 0; b < VSB_BONES; b++)
      for (int c = 0; c < 4; c++) begin
        q = rand_req(OP_LOAD);
        q.bone_index = 6'(b);
        q.slot = 2'(c);
        send_req(q);
      end
  endtask

  // one well-formed vertex with its blend entries
  task automatic send_vertex();
    in_req_t q;
    int n;
    q = rand_req(OP_VERTEX);
    send_req(q);
    n = sb.pending;
    for (int i = 0; i < n; i++) send_req(rand_req(OP_BLEND));
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(out_rsp);
      if (hold_out) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(0, 99) < 30);
    end
  end

  initial begin
    in_req_t q;
    int r;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RIGID_MODE;
    cfg_data = '0;
    hold_out = 1'b0;
    stim_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_cfg(CFG_VERTEX_COUNT, 16'd5);
    load_all_bones();

    // directed: extremes, every operation, odd cases
    q = rand_req(OP_VERTEX);
    q.coord_x = 32'sh7FFF_FFFF; q.coord_y = 32'sh8000_0000; q.coord_z = '0;
    q.normal_x = 16'sh7FFF; q.normal_y = 16'sh8000; q.normal_z = '0;
    q.tex_u = '1; q.tex_v = '0; q.slot = 2'd0; q.bone_index = 6'd63;
    send_req(q);
    q.tex_u = '0; q.tex_v = '1; q.bone_index = 6'd0; q.slot = 2'd3;
    send_req(q);
    q = rand_req(OP_BLEND); q.weight = 16'hFFFF; send_req(q);
    q = rand_req(OP_LOAD); q.bone_index = 6'd5; send_req(q);   // load mid-vertex
    q = rand_req(OP_BLEND); q.weight = '0; send_req(q);
    q = rand_req(OP_BLEND); q.coord_x = 32'sh8000_0000; send_req(q);
    send_req(rand_req(OP_BLEND));                              // nothing pending
    q = rand_req(OP_VERTEX); q.slot = 2'd2; send_req(q);
    send_req(rand_req(OP_BLEND));
    q = rand_req(OP_VERTEX); q.slot = 2'd0; send_req(q);       // drops pending one
    q = rand_req(OP_VERTEX); q.operation = 2'd3; send_req(q);
    q = rand_req(OP_VERTEX); q.slot = 2'd1; send_req(q);
    q = rand_req(OP_BLEND); q.weight = 16'h8000; send_req(q);
    drain();

    write_cfg(CFG_RIGID_MODE, 16'd1);
    write_cfg(CFG_RIGID_BONE, 16'd63);
    write_cfg(CFG_VERTEX_COUNT, 16'd0);
    for (int i = 0; i < 6; i++) send_req(rand_req(OP_VERTEX));
    drain();
    write_cfg(CFG_RIGID_BONE, 16'd0);
    write_cfg(CFG_VERTEX_COUNT, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_req(rand_req(OP_VERTEX));
    drain();

    // random phases through several settings
    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(CFG_RIGID_MODE, (ph == 2) ? 16'd1 : 16'd0);
      write_cfg(CFG_RIGID_BONE, 16'($urandom_range(0, 63)));
      write_cfg(CFG_VERTEX_COUNT, (ph == 3) ? 16'd1 : 16'($urandom_range(1, 9)));
      if (ph == 1) begin
        // long receiver hold-off while requests keep coming
        fork
          begin
            hold_out = 1'b1;
            repeat (300) @(posedge clk);
            hold_out = 1'b0;
          end
          for (int i = 0; i < 40; i++) send_vertex();
        join
      end
      for (int i = 0; i < 220; i++) begin
        r = $urandom_range(0, 99);
        if (r < 80) send_vertex();
        else if (r < 88) send_req(rand_req(OP_LOAD));
        else if (r < 96) send_req(rand_req(OP_BLEND));
        else send_req(rand_req(2'd3));
      end
      drain();
    end

    stim_done = 1'b1;
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

`default_nettype wire

// ----- sim.f -----
design/vsb_pkg.sv
design/vsb_datapath.sv
design/vsb_ctrl.sv
design/vertex_skinning_blend_core.sv
bench/tb_top.sv
